### design/assert_macros.svh
// Assertion macros shared by the multi-stack store RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check on every clock edge outside of reset
`define BMSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every clock edge, reset included
`define BMSS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMSS_ASSERT(lbl, prop, msg)
`define BMSS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### design/bmss_pkg.sv
// Shared types and codes for the balanced multi-stack store.
// No dependencies; bmss_fill and balanced_multi_stack_store import this package.
package bmss_pkg;

  // Default sizing
  localparam int DEF_NUM_STACKS  = 3;
  localparam int DEF_STACK_DEPTH = 32;
  localparam int DEF_DATA_WIDTH  = 8;

  // Fixed field widths
  localparam int CNT_W = 6;
  localparam int STK_W = 3;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_STACK = 3'd1;
  localparam logic [2:0] ST_BAD_POS   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
    logic [2:0] stack_sel;
    logic [5:0] position;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data;
    logic       found;
    logic [2:0] chosen_stack;
  } out_t;

  // Fill count update request
  typedef struct packed {
    logic             inc;
    logic             dec;
    logic [STK_W-1:0] sel;
  } cnt_cmd_t;

endpackage

### design/bmss_mem.sv
// Element store: single-port-write, single-port-read synchronous RAM.
// Read data is registered. Uses no package.
module bmss_mem #(
  parameter int DEPTH = 96,
  parameter int AW    = 7,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/bmss_fill.sv
// Per-stack fill counters with least-filled and most-filled selection.
// Depends on bmss_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bmss_fill #(
  parameter int NUM_STACKS  = bmss_pkg::DEF_NUM_STACKS,
  parameter int STACK_DEPTH = bmss_pkg::DEF_STACK_DEPTH
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  bmss_pkg::cnt_cmd_t                          cmd_i,
  output logic [NUM_STACKS-1:0][bmss_pkg::CNT_W-1:0]  cnt_o,
  output logic [bmss_pkg::STK_W-1:0]                  least_o,
  output logic [bmss_pkg::STK_W-1:0]                  most_o
);
  import bmss_pkg::*;

  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  logic [NUM_STACKS-1:0][CNT_W-1:0] cnt_r;
  logic [SW-1:0]                    idx;
  logic [SW-1:0]                    least;
  logic [SW-1:0]                    most;

  assign idx = cmd_i.sel[SW-1:0];

  // Advance or drop the selected count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd_i.inc) begin
      cnt_r[idx] <= cnt_r[idx] + CNT_W'(1);
    end else if (cmd_i.dec) begin
      cnt_r[idx] <= cnt_r[idx] - CNT_W'(1);
    end
  end

  // Pick least and most filled, ties to the lowest stack
  always_comb begin
    least = '0;
    most  = '0;
    for (int s = 1; s < NUM_STACKS; s++) begin
      if (cnt_r[s] < cnt_r[least]) begin
        least = SW'(s);
      end
      if (cnt_r[s] > cnt_r[most]) begin
        most = SW'(s);
      end
    end
  end

  assign cnt_o   = cnt_r;
  assign least_o = STK_W'(least);
  assign most_o  = STK_W'(most);

  `BMSS_ASSERT(a_one_cmd, !(cmd_i.inc && cmd_i.dec), "count push and pop together")
  `BMSS_ASSERT(a_no_overfill, cmd_i.inc |-> cnt_r[idx] < CNT_W'(STACK_DEPTH), "push on full stack")
  `BMSS_ASSERT(a_no_underflow, cmd_i.dec |-> cnt_r[idx] != '0, "pop on empty stack")
  `BMSS_ASSERT(a_sel_range, (least_o < STK_W'(NUM_STACKS)) || (NUM_STACKS == 8), "bad least pick")

  for (genvar g = 0; g < NUM_STACKS; g++) begin : g_bound
    `BMSS_ASSERT(a_cnt_bound, cnt_r[g] <= CNT_W'(STACK_DEPTH), "fill count above depth")
  end

endmodule

### design/balanced_multi_stack_store.sv
// Balanced multi-stack store: NUM_STACKS bounded stacks held in one RAM.
// Input channel in_valid/in_ready/in_data carries a request (insert, remove,
// read at position, find value); output channel out_valid/out_ready/out_data
// returns exactly one result per request, in order.
// Insert pushes onto the least-filled stack, remove pops the most-filled one,
// ties to the lowest stack number.
// Path from accept to out_valid, with the output free:
//   insert, full, empty, bad stack, bad position: result register, then
//   output register
//   remove, read: RAM read register, result register, output register
//   find: the scan reads one element per cycle through the single RAM read
//   port and stops at the first match.
// One request is in work at a time; the next is taken once the previous
// result has moved into the output register, so a stalled receiver holds
// one finished result while another request is worked on.
// Reset (rst_n low, synchronous) empties all stacks and drops any pending
// result; RAM contents are not cleared.
`include "assert_macros.svh"
module balanced_multi_stack_store #(
  parameter int NUM_STACKS  = bmss_pkg::DEF_NUM_STACKS,
  parameter int STACK_DEPTH = bmss_pkg::DEF_STACK_DEPTH,
  parameter int DATA_WIDTH  = bmss_pkg::DEF_DATA_WIDTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bmss_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bmss_pkg::out_t out_data
);
  import bmss_pkg::*;

  localparam int TOTAL = NUM_STACKS * STACK_DEPTH;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SCW   = $clog2(NUM_STACKS + 1);
  localparam logic [STK_W:0] NS_EXT = (STK_W + 1)'(NUM_STACKS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WAIT = 4'b0010,
    S_FIND = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  in_t                     req_r, req_nxt;
  out_t                    res_r, res_nxt;
  out_t                    out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SCW-1:0]          scan_s_r, scan_s_nxt;
  logic [CNT_W-1:0]        scan_i_r, scan_i_nxt;
  logic [AW-1:0]           base_r, base_nxt;
  logic                    cmp_v_r, cmp_v_nxt;

  logic                    in_fire;
  logic                    out_free;
  cnt_cmd_t                cmd;
  logic [NUM_STACKS-1:0][CNT_W-1:0] cnt;
  logic [STK_W-1:0]        least;
  logic [STK_W-1:0]        most;
  logic [CNT_W-1:0]        cnt_least;
  logic [CNT_W-1:0]        cnt_most;
  logic [CNT_W-1:0]        cnt_sel;
  logic [CNT_W-1:0]        cnt_scan;
  logic                    scan_live;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic [DATA_WIDTH-1:0]   mem_wd;
  logic                    mem_re;
  logic [AW-1:0]           mem_ra;
  logic [DATA_WIDTH-1:0]   mem_rd;

  // Flat RAM address of element i of stack s
  function automatic logic [AW-1:0] slot_addr(input logic [STK_W-1:0] s,
                                               input logic [CNT_W-1:0] i);
    return AW'(AW'(s[SW-1:0]) * AW'(STACK_DEPTH)) + AW'(i);
  endfunction

  bmss_fill #(
    .NUM_STACKS  (NUM_STACKS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_fill (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_i   (cmd),
    .cnt_o   (cnt),
    .least_o (least),
    .most_o  (most)
  );

  bmss_mem #(
    .DEPTH (TOTAL),
    .AW    (AW),
    .DW    (DATA_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cnt_least = cnt[least[SW-1:0]];
  assign cnt_most  = cnt[most[SW-1:0]];
  assign cnt_sel   = cnt[in_data.stack_sel[SW-1:0]];
  assign scan_live = ({{(STK_W + 1 - SCW){1'b0}}, scan_s_r} < NS_EXT);
  assign cnt_scan  = scan_live ? cnt[scan_s_r[SW-1:0]] : '0;

  // Sequencer: accept, read-modify-write the store, scan for find
  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    res_nxt    = res_r;
    scan_s_nxt = scan_s_r;
    scan_i_nxt = scan_i_r;
    base_nxt   = base_r;
    cmp_v_nxt  = cmp_v_r;
    cmd        = '0;
    mem_we     = 1'b0;
    mem_wa     = slot_addr(least, cnt_least);
    mem_wd     = DATA_WIDTH'(in_data.value);
    mem_re     = 1'b0;
    mem_ra     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt   = in_data;
          res_nxt   = '0;
          state_nxt = S_DONE;
          unique case (in_data.op)
            OP_INSERT: begin
              if (cnt_least >= CNT_W'(STACK_DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else begin
                mem_we               = 1'b1;
                cmd.inc              = 1'b1;
                cmd.sel              = least;
                res_nxt.chosen_stack = least;
              end
            end
            OP_REMOVE: begin
              if (cnt_most == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                mem_re               = 1'b1;
                mem_ra               = slot_addr(most, cnt_most - CNT_W'(1));
                cmd.dec              = 1'b1;
                cmd.sel              = most;
                res_nxt.chosen_stack = most;
                state_nxt            = S_WAIT;
              end
            end
            OP_READ: begin
              if ({1'b0, in_data.stack_sel} >= NS_EXT) begin
                res_nxt.status = ST_BAD_STACK;
              end else if (in_data.position >= cnt_sel) begin
                res_nxt.status = ST_BAD_POS;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = slot_addr(in_data.stack_sel, in_data.position);
                state_nxt = S_WAIT;
              end
            end
            OP_FIND: begin
              scan_s_nxt = '0;
              scan_i_nxt = '0;
              base_nxt   = '0;
              cmp_v_nxt  = 1'b0;
              state_nxt  = S_FIND;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_WAIT: begin
        // Take the element from the RAM read register
        res_nxt.data = 8'(mem_rd);
        state_nxt    = S_DONE;
      end
      S_FIND: begin
        if (cmp_v_r && (mem_rd == DATA_WIDTH'(req_r.value))) begin
          res_nxt.found = 1'b1;
          state_nxt     = S_DONE;
        end else if (!scan_live && !cmp_v_r) begin
          state_nxt = S_DONE;
        end else if (scan_live && (scan_i_r < cnt_scan)) begin
          // Issue the next element read of this stack
          mem_re     = 1'b1;
          mem_ra     = base_r + AW'(scan_i_r);
          scan_i_nxt = scan_i_r + CNT_W'(1);
          cmp_v_nxt  = 1'b1;
        end else if (scan_live) begin
          // Stack exhausted: move to the next one
          scan_s_nxt = scan_s_r + SCW'(1);
          scan_i_nxt = '0;
          base_nxt   = base_r + AW'(STACK_DEPTH);
          cmp_v_nxt  = 1'b0;
        end else begin
          cmp_v_nxt = 1'b0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: load the finished result, hold while stalled
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if ((state_r == S_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_v_r     <= cmp_v_nxt;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
    scan_s_r <= scan_s_nxt;
    scan_i_r <= scan_i_nxt;
    base_r   <= base_nxt;
  end

  `BMSS_ASSERT_RST(a_reset_idle, !rst_n |=> in_ready && !out_valid, "not idle after reset")
  `BMSS_ASSERT(a_busy_after_accept, in_fire |=> !in_ready, "accepted twice in a row")
  `BMSS_ASSERT(a_fail_clean, out_valid && (out_data.status != ST_OK) |-> (out_data.data == '0) && (out_data.chosen_stack == '0), "failed result carries data")
  `BMSS_ASSERT(a_found_ok, out_valid && out_data.found |-> out_data.status == ST_OK, "found with bad status")
  `BMSS_ASSERT(a_scan_range, (state_r == S_FIND) |-> ({{(STK_W + 1 - SCW){1'b0}}, scan_s_r} <= NS_EXT), "scan past last stack")

endmodule
